// ===== design/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared types and constants for the quaternion point rotation unit.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int QW     = 16;            // quaternion component, Q1.14
    localparam int VW     = 32;            // coordinate, Q15.16
    localparam int VHW    = VW / 2;        // coordinate half word
    localparam int PW     = 2 * QW;        // quaternion product
    localparam int CW     = PW + 2;        // rotation matrix coefficient
    localparam int PHW    = CW + VHW;      // coef * upper half
    localparam int PLW    = CW + VHW + 1;  // coef * lower half (zero extended)
    localparam int HW     = PHW + 2;       // sum of three upper products
    localparam int LW     = PLW + 2;       // sum of three lower products
    localparam int TW     = HW + VHW + 2;  // full-precision row sum
    localparam int RSH    = 28;            // Q44 -> Q16
    localparam int SW     = TW - RSH;      // rounded row sum
    localparam int QDEPTH = 4;             // item queue depth
    localparam int CFG_AW = 2;

    localparam logic [CFG_AW-1:0] CFG_QUAT_X = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_QUAT_Y = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_QUAT_Z = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_QUAT_W = 2'd3;

    localparam logic signed [QW-1:0] QUAT_ONE = 16'sd16384;

    typedef logic signed [CW-1:0] t_coef;
    typedef t_coef t_mat [3][3];

    typedef struct packed {
        logic signed [VW-1:0] z;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] x;
    } t_vec;

endpackage

// ===== design/qvr_front.sv =====
// ----------------------------------------------------------------------------
// qvr_front
// Quaternion registers, rotation matrix build and input capture stage.
// ----------------------------------------------------------------------------
module qvr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [qvr_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [qvr_pkg::QW-1:0]        i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  qvr_pkg::t_vec                 i_vec,
    input  logic                          i_full,
    output logic                          o_push,
    output qvr_pkg::t_vec                 o_push_vec,
    output qvr_pkg::t_mat                 o_mat
);
    import qvr_pkg::*;

    logic signed [QW-1:0] r_qx, r_qy, r_qz, r_qw;
    logic signed [PW-1:0] r_xx, r_yy, r_zz, r_ss, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_mat                 r_mat;
    logic                 r_in_valid;
    t_vec                 r_in_vec;
    logic                 accept;

    function automatic t_coef ext(input logic signed [PW-1:0] p);
        return t_coef'(p);
    endfunction

    function automatic t_coef dbl(input logic signed [PW-1:0] p);
        return t_coef'(p) <<< 1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx <= '0;
            r_qy <= '0;
            r_qz <= '0;
            r_qw <= QUAT_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_QUAT_X: r_qx <= i_cfg_data;
                CFG_QUAT_Y: r_qy <= i_cfg_data;
                CFG_QUAT_Z: r_qz <= i_cfg_data;
                CFG_QUAT_W: r_qw <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // quaternion products, then matrix sums
    always_ff @(posedge i_clk) begin
        r_xx <= r_qx * r_qx;
        r_yy <= r_qy * r_qy;
        r_zz <= r_qz * r_qz;
        r_ss <= r_qw * r_qw;
        r_xy <= r_qx * r_qy;
        r_xz <= r_qx * r_qz;
        r_yz <= r_qy * r_qz;
        r_wx <= r_qw * r_qx;
        r_wy <= r_qw * r_qy;
        r_wz <= r_qw * r_qz;

        r_mat[0][0] <= ext(r_ss) + ext(r_xx) - ext(r_yy) - ext(r_zz);
        r_mat[0][1] <= dbl(r_xy) - dbl(r_wz);
        r_mat[0][2] <= dbl(r_xz) + dbl(r_wy);
        r_mat[1][0] <= dbl(r_xy) + dbl(r_wz);
        r_mat[1][1] <= ext(r_ss) - ext(r_xx) + ext(r_yy) - ext(r_zz);
        r_mat[1][2] <= dbl(r_yz) - dbl(r_wx);
        r_mat[2][0] <= dbl(r_xz) - dbl(r_wy);
        r_mat[2][1] <= dbl(r_yz) + dbl(r_wx);
        r_mat[2][2] <= ext(r_ss) - ext(r_xx) - ext(r_yy) + ext(r_zz);
    end

    assign o_mat = r_mat;

    assign s_axis_tready = !r_in_valid || !i_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_push        = r_in_valid && !i_full;
    assign o_push_vec    = r_in_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (o_push) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_vec <= i_vec;
        end
    end

endmodule

// ===== design/qvr_fifo.sv =====
// ----------------------------------------------------------------------------
// qvr_fifo
// Short item queue between capture stage and arithmetic pipeline.
// ----------------------------------------------------------------------------
module qvr_fifo #(
    parameter int DEPTH = qvr_pkg::QDEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qvr_pkg::t_vec i_data,
    input  logic          i_pop,
    output qvr_pkg::t_vec o_data,
    output logic          o_full,
    output logic          o_empty
);
    import qvr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_vec          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [NW-1:0] r_count;
    logic          do_push, do_pop;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/qvr_back.sv =====
// ----------------------------------------------------------------------------
// qvr_back
// Matrix-vector pipeline: operand fetch, split products, row sums,
// rounding and saturation into the output register.
// ----------------------------------------------------------------------------
module qvr_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  qvr_pkg::t_vec                i_vec,
    output logic                         o_pop,
    input  qvr_pkg::t_mat                i_mat,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output qvr_pkg::t_vec                o_rot,
    output logic                         o_clipped
);
    import qvr_pkg::*;

    logic                  ce;
    logic                  r0_v, r1_v, r2_v, r_out_v;
    t_vec                  r0_vec;
    logic signed [PHW-1:0] ph [3][3];
    logic signed [PLW-1:0] pl [3][3];
    logic signed [PHW-1:0] r1_ph [3][3];
    logic signed [PLW-1:0] r1_pl [3][3];
    logic signed [HW-1:0]  r2_hi [3];
    logic signed [LW-1:0]  r2_lo [3];
    logic signed [VW-1:0]  sat [3];
    logic [2:0]            clip;
    t_vec                  r_rot;
    logic                  r_clip;
    logic signed [VW-1:0]  vc [3];

    assign ce    = !r_out_v || m_axis_tready;
    assign o_pop = ce && !i_empty;

    assign vc[0] = r0_vec.x;
    assign vc[1] = r0_vec.y;
    assign vc[2] = r0_vec.z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ph[i][j] = PHW'(i_mat[i][j] * $signed(vc[j][VW-1:VHW]));
                pl[i][j] = PLW'(i_mat[i][j] * $signed({1'b0, vc[j][VHW-1:0]}));
            end
        end
    end

    // round half up at Q44 -> Q16, then clamp to 32 bits
    always_comb begin
        logic signed [TW-1:0] tot;
        logic signed [SW-1:0] sh;
        logic [SW-VW:0]       top;
        for (int i = 0; i < 3; i++) begin
            tot = (TW'(r2_hi[i]) <<< VHW) + TW'(r2_lo[i]) + (TW'(1) <<< (RSH - 1));
            sh  = SW'(tot >>> RSH);
            top = sh[SW-1:VW-1];
            clip[i] = !((&top) || !(|top));
            if (!clip[i]) begin
                sat[i] = sh[VW-1:0];
            end else if (sh[SW-1]) begin
                sat[i] = {1'b1, {(VW-1){1'b0}}};
            end else begin
                sat[i] = {1'b0, {(VW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v    <= 1'b0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (ce) begin
            r0_v    <= !i_empty;
            r1_v    <= r0_v;
            r2_v    <= r1_v;
            r_out_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r0_vec <= i_vec;
            r1_ph  <= ph;
            r1_pl  <= pl;
            for (int i = 0; i < 3; i++) begin
                r2_hi[i] <= HW'(r1_ph[i][0]) + HW'(r1_ph[i][1]) + HW'(r1_ph[i][2]);
                r2_lo[i] <= LW'(r1_pl[i][0]) + LW'(r1_pl[i][1]) + LW'(r1_pl[i][2]);
            end
            r_rot.x <= sat[0];
            r_rot.y <= sat[1];
            r_rot.z <= sat[2];
            r_clip  <= |clip;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign o_rot         = r_rot;
    assign o_clipped     = r_clip;

endmodule

// ===== design/quaternion_vector_rotate_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit
// Rotates a stream of Q15.16 points by a configured Q1.14 quaternion,
// r = 2(u.v)u + (s*s - u.u)v + 2s(u x v), rounded and saturated to 32 bits.
//
//   channel   dir   handshake              payload
//   s_axis    in    tvalid/tready          tdata: vec_x, vec_y, vec_z
//   m_axis    out   tvalid/tready          tdata: rot_x, rot_y, rot_z; tuser: clipped
//   cfg       in    i_cfg_we               i_cfg_addr, i_cfg_data
//
// One point per cycle sustained while m_axis_tready stays high; the input
// transfer loads the capture register, and the point then passes the queue,
// fetch, multiply, row sum and round/clamp registers to the output.
// The nine 34x17 and nine 34x16 multipliers set the pipeline depth.
// Reset loads the identity quaternion; writes reach r_mat via the product regs.
// Output stall freezes the back pipeline; the queue keeps input open until full.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_unit #(
    parameter int QDEPTH = qvr_pkg::QDEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [qvr_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [qvr_pkg::QW-1:0]        i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [3*qvr_pkg::VW-1:0]      s_axis_tdata,   // vec_x, vec_y, vec_z
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [3*qvr_pkg::VW-1:0]      m_axis_tdata,   // rot_x, rot_y, rot_z
    output logic [0:0]                    m_axis_tuser    // clipped
);
    import qvr_pkg::*;

    t_vec in_vec, push_vec, q_vec, rot;
    t_mat mat;
    logic push, pop, full, empty, clipped;

    assign in_vec = s_axis_tdata;

    qvr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_vec         (in_vec),
        .i_full        (full),
        .o_push        (push),
        .o_push_vec    (push_vec),
        .o_mat         (mat)
    );

    qvr_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_vec),
        .i_pop   (pop),
        .o_data  (q_vec),
        .o_full  (full),
        .o_empty (empty)
    );

    qvr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_vec         (q_vec),
        .o_pop         (pop),
        .i_mat         (mat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_rot         (rot),
        .o_clipped     (clipped)
    );

    assign m_axis_tdata = rot;
    assign m_axis_tuser = clipped;

endmodule
